FILE: rtl/rsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pkg: shared types and constants of the rotated sprite quad pipeline
// Particle and quad request layouts, config register codes, stage numbering
// and the fixed-point constants of the parabolic sine/cosine approximation.
// ----------------------------------------------------------------------------
package rsq_pkg;

    // pipeline depth and stage numbering
    localparam int NSTAGE    = 8;
    localparam int ST_ANGLE  = 0;  // angle * 2/pi, extents scaled, position offset
    localparam int ST_SQUARE = 1;  // remainder squared
    localparam int ST_CURVE  = 2;  // curvature product
    localparam int ST_TRIG   = 3;  // sine / cosine with quadrant fold
    localparam int ST_PROD   = 4;  // extent x trig partial products
    localparam int ST_TERM   = 5;  // rotated terms
    localparam int ST_DISP   = 6;  // corner displacements
    localparam int ST_CORNER = 7;  // saturated corners

    // scaled extent: 30 x 24 bit product shifted by at least 8 fraction bits
    localparam int SW_W   = 46;
    localparam int TERM_W = 50;
    localparam int D_W    = 51;

    // Q2.30 constants
    localparam logic [29:0]        TWO_OVER_PI_Q30 = 30'd683565276;
    localparam logic signed [31:0] CURVE_Q30       = -32'sd874025845;
    localparam logic signed [31:0] CROSS_Q30       = 32'sd755377373;

    localparam logic [16:0] OPACITY_ONE = 17'h10000;

    typedef enum logic [1:0] {
        CFG_VIEW_X = 2'd0,
        CFG_VIEW_Y = 2'd1,
        CFG_HALF_W = 2'd2,
        CFG_HALF_H = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] view_origin_x;
        logic signed [31:0] view_origin_y;
        logic [29:0]        half_extent_x;
        logic [29:0]        half_extent_y;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] life_left;
        logic [23:0]        size_factor;
        logic signed [31:0] turn_angle;
    } t_particle;

    typedef struct packed {
        logic signed [31:0] corner0_x;
        logic signed [31:0] corner0_y;
        logic signed [31:0] corner1_x;
        logic signed [31:0] corner1_y;
        logic signed [31:0] corner2_x;
        logic signed [31:0] corner2_y;
        logic signed [31:0] corner3_x;
        logic signed [31:0] corner3_y;
        logic [16:0]        opacity;
    } t_quad;

    // per-stage load enables and valid bits
    typedef struct packed {
        logic [NSTAGE-1:0] ld;
        logic [NSTAGE-1:0] vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } t_trig;

    typedef struct packed {
        logic signed [D_W-1:0] dx0;
        logic signed [D_W-1:0] dy0;
        logic signed [D_W-1:0] dx1;
        logic signed [D_W-1:0] dy1;
    } t_disp;

endpackage

FILE: rtl/rsq_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_stream_if: valid/ready stream channel
// Carries one request per accepted cycle; payload type set per instance.
// ----------------------------------------------------------------------------
interface rsq_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rotated_sprite_quad_vertices.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sprite_quad_vertices: rotated sprite quad corners per particle
// Throughput: one particle per cycle while the output is not stalled; the eight
//   stages follow the chain of multiplies (angle scale, square, curvature, extent x trig) and adds.
// A stalled output holds only the stages behind it; bubbles are filled.
// Reset (synchronous, active low) clears the stage valid bits and the config.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_vertices #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsq_stream_if.sink   i_item,
    rsq_stream_if.source o_quad,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    rsq_pkg::t_cfg      r_cfg;
    rsq_pkg::t_pipe_ctl w_ctl;
    rsq_pkg::t_trig     w_trig;
    rsq_pkg::t_disp     w_disp;
    rsq_pkg::t_particle w_item;
    rsq_pkg::t_quad     w_quad;

    assign w_item = i_item.data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (rsq_pkg::t_cfg_idx'(i_cfg_idx))
                rsq_pkg::CFG_VIEW_X: r_cfg.view_origin_x <= i_cfg_data;
                rsq_pkg::CFG_VIEW_Y: r_cfg.view_origin_y <= i_cfg_data;
                rsq_pkg::CFG_HALF_W: r_cfg.half_extent_x <= i_cfg_data[29:0];
                rsq_pkg::CFG_HALF_H: r_cfg.half_extent_y <= i_cfg_data[29:0];
                default: ;
            endcase
        end
    end

    rsq_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_out_ready (o_quad.ready),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_quad.valid),
        .o_ctl       (w_ctl)
    );

    rsq_sincos #(.FRACTION_BITS(FRACTION_BITS)) u_sincos (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_angle (w_item.turn_angle),
        .o_trig  (w_trig)
    );

    rsq_rotate #(.FRACTION_BITS(FRACTION_BITS)) u_rotate (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_half_w (r_cfg.half_extent_x),
        .i_half_h (r_cfg.half_extent_y),
        .i_scale  (w_item.size_factor),
        .i_trig   (w_trig),
        .o_disp   (w_disp)
    );

    rsq_corner #(.FRACTION_BITS(FRACTION_BITS)) u_corner (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_view_x (r_cfg.view_origin_x),
        .i_view_y (r_cfg.view_origin_y),
        .i_pos_x  (w_item.pos_x),
        .i_pos_y  (w_item.pos_y),
        .i_life   (w_item.life_left),
        .i_disp   (w_disp),
        .o_quad   (w_quad)
    );

    assign o_quad.data = w_quad;

    // an accepted request occupies the first stage next cycle
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> w_ctl.vld[rsq_pkg::ST_ANGLE])
        else $error("accepted particle missing from first stage");

    // a full pipeline behind a stalled output keeps every request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_ctl.vld) && !o_quad.ready |=> (&w_ctl.vld))
        else $error("request dropped while output stalled");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_ctl.vld == '0))
        else $error("valid bits not cleared by reset");

    // opacity never exceeds one
    a_opac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quad.valid |-> (o_quad.data.opacity <= rsq_pkg::OPACITY_ONE))
        else $error("opacity above one");
endmodule

FILE: rtl/rsq_pipe_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pipe_ctl: pipeline valid bits and stall control
// A stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out and a stalled output only holds the stages behind it.
// ----------------------------------------------------------------------------
module rsq_pipe_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output rsq_pkg::t_pipe_ctl  o_ctl
);
    localparam int N = rsq_pkg::NSTAGE;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N-1:0] w_rdy;

    // ready chain from the output back to the input
    always_comb begin
        w_rdy[N-1] = !r_vld[N-1] || i_out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // valid bits move with the data
    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < N; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N-1];
    assign o_ctl.ld    = w_rdy;
    assign o_ctl.vld   = r_vld;
endmodule

FILE: rtl/rsq_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_sincos: quadrant-folded parabolic sine and cosine
// Four stages: angle scaling, remainder square, curvature product, then
// the shared term with quadrant swap and sign flips.
// ----------------------------------------------------------------------------
module rsq_sincos #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  rsq_pkg::t_pipe_ctl i_ctl,
    input  logic signed [31:0] i_angle,
    output rsq_pkg::t_trig     o_trig
);
    // angle * 2/pi, Q2.30 constant
    logic signed [62:0] w_ang_ext;
    logic signed [62:0] w_k_ext;
    logic signed [62:0] w_ang_prod;
    logic [31:0]        r_raw;

    assign w_ang_ext  = {{31{i_angle[31]}}, i_angle};
    assign w_k_ext    = 63'(rsq_pkg::TWO_OVER_PI_Q30);
    assign w_ang_prod = w_ang_ext * w_k_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_ANGLE]) begin
            r_raw <= w_ang_prod[FRACTION_BITS +: 32];
        end
    end

    // remainder minus one half, then squared (Q.30)
    logic signed [29:0] w_r;
    logic signed [59:0] w_rsq;
    logic signed [29:0] r_r1;
    logic [1:0]         r_q1;
    logic [28:0]        r_r2;

    assign w_r   = {~r_raw[29], r_raw[28:0]};
    assign w_rsq = w_r * w_r;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_SQUARE]) begin
            r_r1 <= w_r;
            r_q1 <= r_raw[31:30];
            r_r2 <= w_rsq[58:30];
        end
    end

    // curvature times r squared, floored to Q.30
    logic signed [63:0] w_cv_ext;
    logic signed [63:0] w_r2_ext;
    logic signed [63:0] w_cv_prod;
    logic signed [29:0] r_r2b;
    logic [1:0]         r_q2;
    logic signed [29:0] r_shp;

    assign w_cv_ext  = {{32{rsq_pkg::CURVE_Q30[31]}}, rsq_pkg::CURVE_Q30};
    assign w_r2_ext  = 64'(r_r2);
    assign w_cv_prod = w_cv_ext * w_r2_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_CURVE]) begin
            r_r2b <= r_r1;
            r_q2  <= r_q1;
            r_shp <= w_cv_prod[59:30];
        end
    end

    // shared term, swap on odd quadrants, sign by quadrant
    logic signed [31:0] w_shared;
    logic signed [31:0] w_rx;
    logic signed [31:0] w_s0;
    logic signed [31:0] w_c0;
    logic signed [31:0] w_s1;
    logic signed [31:0] w_c1;
    rsq_pkg::t_trig     r_trig;

    always_comb begin
        w_shared = {{2{r_shp[29]}}, r_shp} + rsq_pkg::CROSS_Q30;
        w_rx     = {{2{r_r2b[29]}}, r_r2b};
        w_s0     = w_shared + w_rx;
        w_c0     = w_shared - w_rx;
        if (r_q2[0]) begin
            w_s1 = w_c0;
            w_c1 = w_s0;
        end else begin
            w_s1 = w_s0;
            w_c1 = w_c0;
        end
        if (r_q2[1]) begin
            w_s1 = -w_s1;
        end
        if (r_q2[1] ^ r_q2[0]) begin
            w_c1 = -w_c1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_TRIG]) begin
            r_trig.s <= w_s1;
            r_trig.c <= w_c1;
        end
    end

    assign o_trig = r_trig;
endmodule

FILE: rtl/rsq_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_rotate: scaled half extents rotated by sine and cosine
// Extents are scaled at entry and carried until the trig values arrive;
// each extent x trig product is split at bit 30 into two partial products.
// ----------------------------------------------------------------------------
module rsq_rotate #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  rsq_pkg::t_pipe_ctl i_ctl,
    input  logic [29:0]        i_half_w,
    input  logic [29:0]        i_half_h,
    input  logic [23:0]        i_scale,
    input  rsq_pkg::t_trig     i_trig,
    output rsq_pkg::t_disp     o_disp
);
    localparam int SW_W   = rsq_pkg::SW_W;
    localparam int TERM_W = rsq_pkg::TERM_W;
    localparam int D_W    = rsq_pkg::D_W;

    // high part (bits 45:30) times a trig value, exact in 49 bits
    function automatic logic signed [48:0] mul_hi(input logic [SW_W-1:0] a,
                                                  input logic signed [31:0] b);
        logic signed [48:0] ea;
        logic signed [48:0] eb;
        ea = {33'b0, a[SW_W-1:30]};
        eb = {{17{b[31]}}, b};
        return ea * eb;
    endfunction

    // low 30 bits times a trig value, exact in 63 bits
    function automatic logic signed [62:0] mul_lo(input logic [SW_W-1:0] a,
                                                  input logic signed [31:0] b);
        logic signed [62:0] ea;
        logic signed [62:0] eb;
        ea = {33'b0, a[29:0]};
        eb = {{31{b[31]}}, b};
        return ea * eb;
    endfunction

    // hi*b + floor(lo*b / 2^30)
    function automatic logic signed [TERM_W-1:0] join_term(input logic signed [48:0] ph,
                                                           input logic signed [62:0] pl);
        logic signed [TERM_W-1:0] eh;
        logic signed [TERM_W-1:0] el;
        eh = {{(TERM_W-49){ph[48]}}, ph};
        el = {{(TERM_W-33){pl[62]}}, pl[62:30]};
        return eh + el;
    endfunction

    // scaled extents and their delay line up to the trig stage
    logic [53:0]     w_sw_prod;
    logic [53:0]     w_sh_prod;
    logic [SW_W-1:0] w_sw;
    logic [SW_W-1:0] w_sh;
    logic [SW_W-1:0] r_sw [rsq_pkg::ST_ANGLE:rsq_pkg::ST_TRIG];
    logic [SW_W-1:0] r_sh [rsq_pkg::ST_ANGLE:rsq_pkg::ST_TRIG];

    assign w_sw_prod = 54'(i_half_w) * 54'(i_scale);
    assign w_sh_prod = 54'(i_half_h) * 54'(i_scale);
    assign w_sw      = SW_W'(w_sw_prod >> FRACTION_BITS);
    assign w_sh      = SW_W'(w_sh_prod >> FRACTION_BITS);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_ANGLE]) begin
            r_sw[rsq_pkg::ST_ANGLE] <= w_sw;
            r_sh[rsq_pkg::ST_ANGLE] <= w_sh;
        end
        for (int k = rsq_pkg::ST_ANGLE + 1; k <= rsq_pkg::ST_TRIG; k++) begin
            if (i_ctl.ld[k]) begin
                r_sw[k] <= r_sw[k-1];
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    // partial products
    logic signed [48:0] r_swc_h, r_shs_h, r_sws_h, r_shc_h;
    logic signed [62:0] r_swc_l, r_shs_l, r_sws_l, r_shc_l;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_PROD]) begin
            r_swc_h <= mul_hi(r_sw[rsq_pkg::ST_TRIG], i_trig.c);
            r_swc_l <= mul_lo(r_sw[rsq_pkg::ST_TRIG], i_trig.c);
            r_shs_h <= mul_hi(r_sh[rsq_pkg::ST_TRIG], i_trig.s);
            r_shs_l <= mul_lo(r_sh[rsq_pkg::ST_TRIG], i_trig.s);
            r_sws_h <= mul_hi(r_sw[rsq_pkg::ST_TRIG], i_trig.s);
            r_sws_l <= mul_lo(r_sw[rsq_pkg::ST_TRIG], i_trig.s);
            r_shc_h <= mul_hi(r_sh[rsq_pkg::ST_TRIG], i_trig.c);
            r_shc_l <= mul_lo(r_sh[rsq_pkg::ST_TRIG], i_trig.c);
        end
    end

    // rotated terms
    logic signed [TERM_W-1:0] r_swc, r_shs, r_sws, r_shc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_TERM]) begin
            r_swc <= join_term(r_swc_h, r_swc_l);
            r_shs <= join_term(r_shs_h, r_shs_l);
            r_sws <= join_term(r_sws_h, r_sws_l);
            r_shc <= join_term(r_shc_h, r_shc_l);
        end
    end

    // corner displacements
    logic signed [D_W-1:0] w_swc, w_shs, w_sws, w_shc;
    rsq_pkg::t_disp        r_disp;

    assign w_swc = {r_swc[TERM_W-1], r_swc};
    assign w_shs = {r_shs[TERM_W-1], r_shs};
    assign w_sws = {r_sws[TERM_W-1], r_sws};
    assign w_shc = {r_shc[TERM_W-1], r_shc};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_DISP]) begin
            r_disp.dx0 <= w_shs - w_swc;
            r_disp.dy0 <= -w_sws - w_shc;
            r_disp.dx1 <= w_swc + w_shs;
            r_disp.dy1 <= w_sws - w_shc;
        end
    end

    assign o_disp = r_disp;
endmodule

FILE: rtl/rsq_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_corner: view offset, opacity and saturated quad corners
// Offset position and clamped opacity are formed at entry, delayed to meet
// the displacements, then the four corners are added and saturated.
// ----------------------------------------------------------------------------
module rsq_corner #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  rsq_pkg::t_pipe_ctl i_ctl,
    input  logic signed [31:0] i_view_x,
    input  logic signed [31:0] i_view_y,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_life,
    input  rsq_pkg::t_disp     i_disp,
    output rsq_pkg::t_quad     o_quad
);
    localparam int D_W   = rsq_pkg::D_W;
    localparam int SUM_W = D_W + 1;
    localparam int ONE_F = 1 << FRACTION_BITS;

    // clamp a wide sum to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic same;
        same = (v[SUM_W-1:31] == '0) || (v[SUM_W-1:31] == '1);
        if (same) begin
            return v[31:0];
        end else if (v[SUM_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    // entry: offset position, life clamp to [0, one]
    logic signed [32:0] w_px;
    logic signed [32:0] w_py;
    logic [24:0]        w_life;
    logic [40:0]        w_opac_wide;

    assign w_px = {i_pos_x[31], i_pos_x} - {i_view_x[31], i_view_x};
    assign w_py = {i_pos_y[31], i_pos_y} - {i_view_y[31], i_view_y};

    always_comb begin
        if (i_life[31]) begin
            w_life = '0;
        end else if (i_life > 32'(ONE_F)) begin
            w_life = 25'(ONE_F);
        end else begin
            w_life = i_life[24:0];
        end
        w_opac_wide = {w_life, 16'b0} >> FRACTION_BITS;
    end

    // delay line to the displacement stage
    logic signed [32:0] r_px   [rsq_pkg::ST_ANGLE:rsq_pkg::ST_DISP];
    logic signed [32:0] r_py   [rsq_pkg::ST_ANGLE:rsq_pkg::ST_DISP];
    logic [16:0]        r_opac [rsq_pkg::ST_ANGLE:rsq_pkg::ST_DISP];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_ANGLE]) begin
            r_px[rsq_pkg::ST_ANGLE]   <= w_px;
            r_py[rsq_pkg::ST_ANGLE]   <= w_py;
            r_opac[rsq_pkg::ST_ANGLE] <= w_opac_wide[16:0];
        end
        for (int k = rsq_pkg::ST_ANGLE + 1; k <= rsq_pkg::ST_DISP; k++) begin
            if (i_ctl.ld[k]) begin
                r_px[k]   <= r_px[k-1];
                r_py[k]   <= r_py[k-1];
                r_opac[k] <= r_opac[k-1];
            end
        end
    end

    // corners: p + d0, p + d1, p - d0, p - d1
    logic signed [SUM_W-1:0] w_px_e, w_py_e;
    logic signed [SUM_W-1:0] w_dx0, w_dy0, w_dx1, w_dy1;
    rsq_pkg::t_quad          r_quad;

    assign w_px_e = {{(SUM_W-33){r_px[rsq_pkg::ST_DISP][32]}}, r_px[rsq_pkg::ST_DISP]};
    assign w_py_e = {{(SUM_W-33){r_py[rsq_pkg::ST_DISP][32]}}, r_py[rsq_pkg::ST_DISP]};
    assign w_dx0  = {i_disp.dx0[D_W-1], i_disp.dx0};
    assign w_dy0  = {i_disp.dy0[D_W-1], i_disp.dy0};
    assign w_dx1  = {i_disp.dx1[D_W-1], i_disp.dx1};
    assign w_dy1  = {i_disp.dy1[D_W-1], i_disp.dy1};

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[rsq_pkg::ST_CORNER]) begin
            r_quad.corner0_x <= sat32(w_px_e + w_dx0);
            r_quad.corner0_y <= sat32(w_py_e + w_dy0);
            r_quad.corner1_x <= sat32(w_px_e + w_dx1);
            r_quad.corner1_y <= sat32(w_py_e + w_dy1);
            r_quad.corner2_x <= sat32(w_px_e - w_dx0);
            r_quad.corner2_y <= sat32(w_py_e - w_dy0);
            r_quad.corner3_x <= sat32(w_px_e - w_dx1);
            r_quad.corner3_y <= sat32(w_py_e - w_dy1);
            r_quad.opacity   <= r_opac[rsq_pkg::ST_DISP];
        end
    end

    assign o_quad = r_quad;
endmodule

FILE: tb/quad_corner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_corner_checker: expected quad corners and opacity per particle
// Watches the config port and both streams. Each accepted particle request is
// turned into its expected quad by a local fixed-point model, and each
// accepted quad request is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module quad_corner_checker #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_item_valid,
    input  logic               i_item_ready,
    input  rsq_pkg::t_particle i_item_data,
    input  logic               i_quad_valid,
    input  logic               i_quad_ready,
    input  rsq_pkg::t_quad     i_quad_data,
    output int                 o_pending,
    output int                 o_fail_count
);

    // Q2.30 constants of the folded parabola
    localparam longint ANGLE_TO_QUAD = 64'sd683565276;   // 2/pi
    localparam longint CURVE         = -64'sd874025845;  // -0.814
    localparam longint PEAK          = 64'sd755377373;   // 0.7035
    localparam longint HALF          = 64'sd536870912;   // 0.5
    localparam longint MASK30        = 64'h3FFF_FFFF;
    localparam longint ONE           = 64'sd1 <<< FRACTION_BITS;

    // local copy of the config registers
    longint view_x;
    longint view_y;
    longint half_w;
    longint half_h;

    rsq_pkg::t_quad quads_due[$];
    int             pending_count;
    int             fail_count;

    assign o_pending    = pending_count;
    assign o_fail_count = fail_count;

    // floor(extent * trig / 2^30), exact
    function automatic longint rotate_term(longint extent, longint trig);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa   = extent;
        wb   = trig;
        prod = (wa * wb) >>> 30;
        return longint'(prod[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic rsq_pkg::t_quad predict_quad(rsq_pkg::t_particle p);
        longint         px, py, life, scale, raw, rem, rsq, shared, sn, cs, swap;
        longint         sw, sh, swc, shs, sws, shc, dx0, dy0, dx1, dy1;
        logic [1:0]     quadrant;
        logic [1:0]     next_quadrant;
        rsq_pkg::t_quad q;

        px    = longint'(p.pos_x) - view_x;
        py    = longint'(p.pos_y) - view_y;
        life  = longint'(p.life_left);
        scale = longint'(p.size_factor);

        // angle in quarter turns, Q.30; floor keeps negative angles right
        raw           = (longint'(p.turn_angle) * ANGLE_TO_QUAD) >>> FRACTION_BITS;
        quadrant      = raw[31:30];
        next_quadrant = quadrant + 2'd1;
        rem           = (raw & MASK30) - HALF;

        rsq    = (rem * rem) >>> 30;
        shared = ((CURVE * rsq) >>> 30) + PEAK;
        sn     = shared + rem;
        cs     = shared - rem;
        if (quadrant[0]) begin
            swap = sn;
            sn   = cs;
            cs   = swap;
        end
        if (quadrant[1])
            sn = -sn;
        if (next_quadrant[1])
            cs = -cs;

        sw  = (half_w * scale) >>> FRACTION_BITS;
        sh  = (half_h * scale) >>> FRACTION_BITS;
        swc = rotate_term(sw, cs);
        shs = rotate_term(sh, sn);
        sws = rotate_term(sw, sn);
        shc = rotate_term(sh, cs);

        dx0 = shs - swc;
        dy0 = -(sws + shc);
        dx1 = swc + shs;
        dy1 = sws - shc;

        q.corner0_x = clamp32(px + dx0);
        q.corner0_y = clamp32(py + dy0);
        q.corner1_x = clamp32(px + dx1);
        q.corner1_y = clamp32(py + dy1);
        q.corner2_x = clamp32(px - dx0);
        q.corner2_y = clamp32(py - dy0);
        q.corner3_x = clamp32(px - dx1);
        q.corner3_y = clamp32(py - dy1);

        // opacity: life clamped to zero..one, rescaled to 16 fraction bits
        if (life < 0)
            life = 0;
        if (life > ONE)
            life = ONE;
        q.opacity = 17'((life <<< 16) >>> FRACTION_BITS);
        return q;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // config writes, then particle requests in, then quad requests out
    always @(posedge i_clk) begin
        rsq_pkg::t_quad want;
        if (!i_rst_n) begin
            view_x        = 0;
            view_y        = 0;
            half_w        = 0;
            half_h        = 0;
            fail_count    = 0;
            pending_count = 0;
            quads_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (rsq_pkg::t_cfg_idx'(i_cfg_idx))
                    rsq_pkg::CFG_VIEW_X: view_x = longint'($signed(i_cfg_data));
                    rsq_pkg::CFG_VIEW_Y: view_y = longint'($signed(i_cfg_data));
                    rsq_pkg::CFG_HALF_W: half_w = longint'(i_cfg_data[29:0]);
                    rsq_pkg::CFG_HALF_H: half_h = longint'(i_cfg_data[29:0]);
                    default: ;
                endcase
            end
            if (i_item_valid && i_item_ready)
                quads_due.push_back(predict_quad(i_item_data));
            if (i_quad_valid && i_quad_ready) begin
                if (quads_due.size() == 0) begin
                    $error("quad request with no particle pending");
                    fail_count++;
                end else begin
                    want = quads_due.pop_front();
                    check_field("corner0_x", want.corner0_x, i_quad_data.corner0_x);
                    check_field("corner0_y", want.corner0_y, i_quad_data.corner0_y);
                    check_field("corner1_x", want.corner1_x, i_quad_data.corner1_x);
                    check_field("corner1_y", want.corner1_y, i_quad_data.corner1_y);
                    check_field("corner2_x", want.corner2_x, i_quad_data.corner2_x);
                    check_field("corner2_y", want.corner2_y, i_quad_data.corner2_y);
                    check_field("corner3_x", want.corner3_x, i_quad_data.corner3_x);
                    check_field("corner3_y", want.corner3_y, i_quad_data.corner3_y);
                    check_field("opacity", want.opacity, i_quad_data.opacity);
                end
            end
            pending_count = quads_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: rotated sprite quad pipeline bench
// Drives particle requests under several viewport and extent settings:
// a directed set of angle, life and overflow corners, and random particles
// with random gaps on the input and random stalls on the output but for one steady stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int     FRACTION_BITS = 16;
    localparam longint ANGLE_TO_QUAD = 64'sd683565276;
    localparam int     DRAIN_CYCLES  = 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        item_taken;
    logic        steady;
    int          pending;
    int          fail_count;

    rsq_stream_if #(.T_DATA(rsq_pkg::t_particle)) item_ch ();
    rsq_stream_if #(.T_DATA(rsq_pkg::t_quad))     quad_ch ();

    rotated_sprite_quad_vertices #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_item    (item_ch),
        .o_quad    (quad_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    quad_corner_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_item_valid(item_ch.valid),
        .i_item_ready(item_ch.ready),
        .i_item_data (item_ch.data),
        .i_quad_valid(quad_ch.valid),
        .i_quad_ready(quad_ch.ready),
        .i_quad_data (quad_ch.data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // 12 ns clock
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // particle request accepted at the last rising edge
    always @(posedge clk)
        item_taken <= item_ch.valid && item_ch.ready && rst_n;

    // output backpressure: ~14% stall, none in steady stretches
    always @(negedge clk)
        quad_ch.ready <= steady || ($urandom_range(99) >= 14);

    function automatic rsq_pkg::t_particle make_particle(logic signed [31:0] px,
                                                         logic signed [31:0] py,
                                                         logic signed [31:0] life,
                                                         logic [23:0] scale,
                                                         logic signed [31:0] angle);
        rsq_pkg::t_particle p;
        p.pos_x       = px;
        p.pos_y       = py;
        p.life_left   = life;
        p.size_factor = scale;
        p.turn_angle  = angle;
        return p;
    endfunction

    // negative angle landing exactly on a quadrant boundary after scaling
    function automatic logic signed [31:0] whole_quadrant_angle();
        longint k;
        longint a;
        longint raw;
        for (k = 1; k <= 20860; k++) begin
            a = -((k <<< 46) / ANGLE_TO_QUAD);
            for (longint d = -1; d <= 1; d++) begin
                raw = ((a + d) * ANGLE_TO_QUAD) >>> FRACTION_BITS;
                if ((raw & 64'h3FFF_FFFF) == 0)
                    return 32'(a + d);
            end
        end
        return -32'sd102944;
    endfunction

    function automatic rsq_pkg::t_particle random_particle();
        rsq_pkg::t_particle p;
        if ($urandom_range(1))
            p.pos_x = $urandom;
        else
            p.pos_x = 32'($urandom_range(33554432)) - 32'd16777216;
        if ($urandom_range(1))
            p.pos_y = $urandom;
        else
            p.pos_y = 32'($urandom_range(33554432)) - 32'd16777216;
        if ($urandom_range(2) == 0)
            p.life_left = $urandom;
        else
            p.life_left = 32'($urandom_range(81920)) - 32'd16384;
        if ($urandom_range(9) < 7)
            p.size_factor = 24'($urandom_range(262144));
        else
            p.size_factor = 24'($urandom);
        if ($urandom_range(9) < 4)
            p.turn_angle = $urandom;
        else
            p.turn_angle = 32'($urandom_range(1048576)) - 32'd524288;
        return p;
    endfunction

    // all four registers, back to back; upper extent bits are don't-care
    task automatic program_view(logic signed [31:0] vx, logic signed [31:0] vy,
                                logic [29:0] hw, logic [29:0] hh);
        rsq_pkg::t_cfg_idx idx;
        for (int i = 0; i < 4; i++) begin
            idx = rsq_pkg::t_cfg_idx'(i);
            case (idx)
                rsq_pkg::CFG_VIEW_X: cfg_data <= vx;
                rsq_pkg::CFG_VIEW_Y: cfg_data <= vy;
                rsq_pkg::CFG_HALF_W: cfg_data <= {2'($urandom), hw};
                default:             cfg_data <= {2'($urandom), hh};
            endcase
            cfg_idx <= idx;
            cfg_we  <= 1'b1;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // valid held low before about one request in seven, except in steady stretches
    task automatic send_particle(rsq_pkg::t_particle p);
        if (!steady && $urandom_range(99) < 14) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= p;
        do @(negedge clk); while (!item_taken);
    endtask

    // stop sending and let every quad request come out
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_particle(random_particle());
    endtask

    task automatic send_directed();
        logic signed [31:0] whole_neg;
        whole_neg = whole_quadrant_angle();
        send_particle(make_particle(0, 0, 0, 24'd0, 0));
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd32768, 24'd65536, 0));
        // quarter, half and three-quarter turns, both directions
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd65536, 24'd65536,
                                    32'sd102944));
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd65536, 24'd65536,
                                    -32'sd102944));
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd65536, 24'd65536,
                                    32'sd205887));
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd65536, 24'd65536,
                                    -32'sd205887));
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd65536, 24'd65536,
                                    32'sd308831));
        send_particle(make_particle(32'sd6553600, 32'sd3276800, 32'sd65536, 24'd65536,
                                    -32'sd308831));
        // negative angle on an exact quadrant boundary, and its neighbors
        send_particle(make_particle(0, 0, 32'sd65536, 24'd131072, whole_neg));
        send_particle(make_particle(0, 0, 32'sd65536, 24'd131072, whole_neg - 1));
        send_particle(make_particle(0, 0, 32'sd65536, 24'd131072, whole_neg + 1));
        // angle extremes
        send_particle(make_particle(0, 0, 32'sd65536, 24'd65536, 32'sh7FFF_FFFF));
        send_particle(make_particle(0, 0, 32'sd65536, 24'd65536, 32'sh8000_0000));
        // life below zero, just below one, above one, and the field extremes
        send_particle(make_particle(0, 0, -32'sd1, 24'd65536, 32'sd12345));
        send_particle(make_particle(0, 0, 32'sd65535, 24'd65536, 32'sd12345));
        send_particle(make_particle(0, 0, 32'sd65537, 24'd65536, 32'sd12345));
        send_particle(make_particle(0, 0, 32'sh7FFF_FFFF, 24'd65536, 32'sd12345));
        send_particle(make_particle(0, 0, 32'sh8000_0000, 24'd65536, 32'sd12345));
        // position and scale extremes, driving the corners into saturation
        send_particle(make_particle(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1,
                                    24'hFF_FFFF, 32'sd51472));
        send_particle(make_particle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1,
                                    24'hFF_FFFF, -32'sd51472));
        send_particle(make_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1,
                                    24'hFF_FFFF, 32'sd154416));
    endtask

    initial begin
        rst_n         = 1'b0;
        steady        = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = rsq_pkg::CFG_VIEW_X;
        cfg_data      = '0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        quad_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero extents, quad collapses onto the position
        send_random(20);
        drain();

        program_view(32'sd229376, -32'sd475136, 30'd1048576, 30'd524288);
        send_directed();
        drain();

        // largest offsets and extents
        program_view(32'sh7FFF_FFFF, 32'sh8000_0000, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
        send_random(60);
        drain();

        program_view(32'sh8000_0000, 32'sh7FFF_FFFF, 30'd0, 30'd536870912);
        send_random(60);
        drain();

        // no gaps and no stalls
        steady = 1'b1;
        program_view($urandom, $urandom, 30'($urandom_range(4194304)),
                     30'($urandom_range(4194304)));
        send_random(120);
        drain();
        steady = 1'b0;

        program_view($urandom, $urandom, 30'($urandom), 30'($urandom));
        send_random(60);
        drain();

        program_view(32'($urandom_range(2097152)) - 32'd1048576,
                     32'($urandom_range(2097152)) - 32'd1048576,
                     30'($urandom_range(8388608)), 30'($urandom_range(8388608)));
        send_random(80);
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rsq_pkg.sv
rtl/rsq_stream_if.sv
rtl/rsq_pipe_ctl.sv
rtl/rsq_sincos.sv
rtl/rsq_rotate.sv
rtl/rsq_corner.sv
rtl/rotated_sprite_quad_vertices.sv
tb/quad_corner_checker.sv
tb/tb.sv
